>>> design/idt_pkg.sv
// Shared constants, codes and types for the isometric diamond tile decoder.
package idt_pkg;

  localparam int HDR_BYTES   = 20;  // five little-endian 32-bit header words
  localparam int HDR_WORDS   = 5;
  localparam int OFFSET_BIAS = 32;  // image data starts at cell offset plus this
  localparam int PIX_BITS    = 12;  // width of the pixel coordinate fields
  localparam int CHAN_BITS   = 8;   // one color channel, one file byte
  localparam int STATUS_BITS = 3;

  typedef enum logic {
    FUNC_BYTE    = 1'b0,
    FUNC_PALETTE = 1'b1
  } func_e;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK       = 3'd0,
    STAT_SMALL    = 3'd1,
    STAT_BLOCKS   = 3'd2,
    STAT_OFFSET   = 3'd3,
    STAT_DIMS     = 3'd4,
    STAT_OVERRUN  = 3'd5,
    STAT_TOOLARGE = 3'd6
  } status_e;

endpackage

>>> design/idt_in_if.sv
// Input channel: file bytes and palette writes with valid/ready handshake.
interface idt_in_if;
  import idt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [CHAN_BITS-1:0] data_byte;
  logic                 last;
  logic [CHAN_BITS-1:0] palette_index;
  logic [CHAN_BITS-1:0] palette_red;
  logic [CHAN_BITS-1:0] palette_green;
  logic [CHAN_BITS-1:0] palette_blue;

  modport source (
    output valid, func, data_byte, last, palette_index,
           palette_red, palette_green, palette_blue,
    input  ready
  );

  modport sink (
    input  valid, func, data_byte, last, palette_index,
           palette_red, palette_green, palette_blue,
    output ready
  );
endinterface

>>> design/idt_out_if.sv
// Output channel: painted pixels and end-of-file status with valid/ready handshake.
interface idt_out_if;
  import idt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [PIX_BITS-1:0]    pixel_x;
  logic [PIX_BITS-1:0]    pixel_y;
  logic [CHAN_BITS-1:0]   red;
  logic [CHAN_BITS-1:0]   green;
  logic [CHAN_BITS-1:0]   blue;
  logic [STATUS_BITS-1:0] status;

  modport source (
    output valid, kind, pixel_x, pixel_y, red, green, blue, status,
    input  ready
  );

  modport sink (
    input  valid, kind, pixel_x, pixel_y, red, green, blue, status,
    output ready
  );
endinterface

>>> design/idt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module idt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/isometric_diamond_tile_decoder_unit.sv
// Palette write: the accept step only. File byte: accept, header, pixel and status steps;
// a byte that ends a diamond row adds steps for the next row's width and start.
// The twentieth byte of a valid header runs the serial row step divider, then the row start step.
// A stalled output holds the pixel or status step; the next byte is taken while a result waits.
// Reset (async, active low) clears the sequencer, header, byte count and row state at once;
// the palette RAM is not cleared and holds garbage until written.
module isometric_diamond_tile_decoder_unit #(
  parameter int COORD_BITS    = 12,
  parameter int POSITION_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  idt_in_if.sink    in_i,
  idt_out_if.source out_o
);
  import idt_pkg::*;

  localparam int CW       = COORD_BITS;
  localparam int PW       = POSITION_BITS;
  localparam int CntBits  = $clog2(COORD_BITS);
  localparam int PalBits  = 3 * CHAN_BITS;
  localparam int PalDepth = 1 << CHAN_BITS;
  localparam logic [32:0] PosMax   = 33'((64'd1 << POSITION_BITS) - 64'd1);
  localparam logic [31:0] CoordMax = 32'((64'd1 << COORD_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_WAIT,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IN,
    ST_HDR,
    ST_DIV,
    ST_START,
    ST_PIX,
    ST_ROW,
    ST_STAT
  } state_e;

  state_e               state_q;
  phase_e               phase_q;
  logic [PW-1:0]        pos_q;
  logic [PW-1:0]        p_q;
  logic                 last_q;
  logic [31:0]          hdr_q [HDR_WORDS];
  logic [CW-1:0]        row_step_q;
  logic [CW-1:0]        row_idx_q;
  logic [CW-1:0]        col_q;
  logic [CW-1:0]        row_width_q;
  logic [CW-1:0]        row_start_q;
  logic [CW-1:0]        rem_q;
  logic [CW-1:0]        quo_q;
  logic [CntBits-1:0]   div_cnt_q;

  logic                 out_valid_q;
  logic                 out_kind_q;
  logic [PIX_BITS-1:0]  out_x_q;
  logic [PIX_BITS-1:0]  out_y_q;
  logic [CHAN_BITS-1:0] out_r_q;
  logic [CHAN_BITS-1:0] out_g_q;
  logic [CHAN_BITS-1:0] out_b_q;
  status_e              out_status_q;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [PW-1:0]        pos_inc;
  logic [2:0]           hdr_idx;
  logic [1:0]           hdr_lane;
  logic [32:0]          data_off;
  logic [CW-1:0]        tile_w;
  logic [CW-1:0]        tile_h;
  logic [CW-1:0]        half_h;
  logic                 blocks_ok;
  logic                 dims_ok;
  logic                 size_ok;
  logic                 pix_due;
  logic [CW-1:0]        div_trial;
  logic                 div_ge;
  logic [CW-1:0]        rem_nx;
  logic [CW-1:0]        quo_nx;
  logic [CW:0]          col_inc;
  logic [CW:0]          row_inc;
  logic [CW:0]          x_sum;
  logic [31:0]          x_wide;
  logic [31:0]          y_wide;
  logic [PalBits-1:0]   pal_rdata;
  status_e              end_status;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IN);

  // Load the result register from the pixel or the status step.
  assign out_load = ((state_q == ST_PIX) && pix_due && out_free)
                 || ((state_q == ST_STAT) && last_q && out_free);

  // Palette store: written by palette transfers, read with the file byte as address.
  idt_ram #(
    .WIDTH(PalBits),
    .DEPTH(PalDepth)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (accept && (in_i.func == FUNC_PALETTE)),
    .waddr_i(in_i.palette_index),
    .wdata_i({in_i.palette_red, in_i.palette_green, in_i.palette_blue}),
    .re_i   (accept && (in_i.func == FUNC_BYTE)),
    .raddr_i(in_i.data_byte),
    .rdata_o(pal_rdata)
  );

  assign pos_inc  = (&pos_q) ? pos_q : pos_q + PW'(1);
  assign hdr_idx  = pos_q[4:2];
  assign hdr_lane = pos_q[1:0];

  assign data_off  = {1'b0, hdr_q[4]} + 33'(OFFSET_BIAS);
  assign tile_w    = hdr_q[2][CW-1:0];
  assign tile_h    = hdr_q[3][CW-1:0];
  assign half_h    = tile_h >> 1;
  assign blocks_ok = (hdr_q[0] == 32'd1) && (hdr_q[1] == 32'd1);
  assign dims_ok   = (hdr_q[3] != 32'd0) && !hdr_q[3][0];
  assign size_ok   = (hdr_q[2] <= CoordMax) && (hdr_q[3] <= CoordMax) && (data_off < PosMax);
  assign pix_due   = (phase_q == PH_PIXELS) && (33'(p_q) >= data_off);

  // One restoring step of the row step divider: width over half the height.
  assign div_trial = {rem_q[CW-2:0], quo_q[CW-1]};
  assign div_ge    = (div_trial >= half_h);
  assign rem_nx    = div_ge ? div_trial - half_h : div_trial;
  assign quo_nx    = {quo_q[CW-2:0], div_ge};

  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc = {1'b0, row_idx_q} + (CW+1)'(1);
  assign x_sum   = {1'b0, row_start_q} + {1'b0, col_q};
  assign x_wide  = 32'(x_sum);
  assign y_wide  = 32'(row_idx_q);

  always_comb begin
    if (33'(pos_q) < 33'(HDR_BYTES)) begin
      end_status = STAT_SMALL;
    end else if (!blocks_ok) begin
      end_status = STAT_BLOCKS;
    end else if (data_off >= PosMax) begin
      end_status = STAT_TOOLARGE;
    end else if (33'(pos_q) <= data_off) begin
      end_status = STAT_OFFSET;
    end else if (!dims_ok) begin
      end_status = STAT_DIMS;
    end else if ((hdr_q[2] > CoordMax) || (hdr_q[3] > CoordMax)) begin
      end_status = STAT_TOOLARGE;
    end else if (phase_q != PH_DONE) begin
      end_status = STAT_OVERRUN;
    end else begin
      end_status = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IN;
      phase_q      <= PH_HEADER;
      pos_q        <= '0;
      p_q          <= '0;
      last_q       <= 1'b0;
      for (int i = 0; i < HDR_WORDS; i++) begin
        hdr_q[i] <= '0;
      end
      row_step_q   <= '0;
      row_idx_q    <= '0;
      col_q        <= '0;
      row_width_q  <= '0;
      row_start_q  <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_PIXEL;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_r_q      <= '0;
      out_g_q      <= '0;
      out_b_q      <= '0;
      out_status_q <= STAT_OK;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IN: begin
          if (accept && (in_i.func == FUNC_BYTE)) begin
            p_q    <= pos_q;
            pos_q  <= pos_inc;
            last_q <= in_i.last;
            if ((phase_q == PH_HEADER) && (33'(pos_q) < 33'(HDR_BYTES))) begin
              hdr_q[hdr_idx][8*hdr_lane +: 8] <= in_i.data_byte;
            end
            state_q <= ST_HDR;
          end
        end
        ST_HDR: begin
          if ((phase_q == PH_HEADER) && (33'(p_q) == 33'(HDR_BYTES - 1))) begin
            if (blocks_ok && dims_ok && size_ok) begin
              rem_q     <= '0;
              quo_q     <= tile_w;
              div_cnt_q <= CntBits'(COORD_BITS - 1);
              state_q   <= ST_DIV;
            end else begin
              phase_q <= PH_DONE;
              state_q <= ST_PIX;
            end
          end else begin
            if ((phase_q == PH_WAIT) && (33'(p_q) == data_off) && (33'(p_q) < PosMax)) begin
              phase_q <= (row_step_q == '0) ? PH_DONE : PH_PIXELS;
            end
            state_q <= ST_PIX;
          end
        end
        ST_DIV: begin
          rem_q     <= rem_nx;
          quo_q     <= quo_nx;
          div_cnt_q <= div_cnt_q - CntBits'(1);
          if (div_cnt_q == '0) begin
            row_step_q  <= quo_nx;
            row_width_q <= quo_nx;
            row_idx_q   <= '0;
            col_q       <= '0;
            phase_q     <= PH_WAIT;
            state_q     <= ST_START;
          end
        end
        ST_START: begin
          // Center the row in the tile width.
          row_start_q <= (tile_w - row_width_q) >> 1;
          state_q     <= ST_STAT;
        end
        ST_PIX: begin
          if (!pix_due) begin
            state_q <= ST_STAT;
          end else if (out_free) begin
            out_kind_q   <= KIND_PIXEL;
            out_x_q      <= x_wide[PIX_BITS-1:0];
            out_y_q      <= y_wide[PIX_BITS-1:0];
            out_r_q      <= pal_rdata[3*CHAN_BITS-1:2*CHAN_BITS];
            out_g_q      <= pal_rdata[2*CHAN_BITS-1:CHAN_BITS];
            out_b_q      <= pal_rdata[CHAN_BITS-1:0];
            out_status_q <= STAT_OK;
            if (col_inc >= {1'b0, row_width_q}) begin
              col_q     <= '0;
              row_idx_q <= row_inc[CW-1:0];
              if (row_inc >= {1'b0, tile_h}) begin
                phase_q <= PH_DONE;
                state_q <= ST_STAT;
              end else begin
                state_q <= ST_ROW;
              end
            end else begin
              col_q   <= col_inc[CW-1:0];
              state_q <= ST_STAT;
            end
          end
        end
        ST_ROW: begin
          // Widen above the middle row, hold at it, narrow below it.
          if (row_idx_q < half_h) begin
            row_width_q <= row_width_q + row_step_q;
          end else if (row_idx_q != half_h) begin
            row_width_q <= row_width_q - row_step_q;
          end
          state_q <= ST_START;
        end
        ST_STAT: begin
          if (!last_q) begin
            state_q <= ST_IN;
          end else if (out_free) begin
            out_kind_q   <= KIND_STATUS;
            out_x_q      <= '0;
            out_y_q      <= '0;
            out_r_q      <= '0;
            out_g_q      <= '0;
            out_b_q      <= '0;
            out_status_q <= end_status;
            // Drop the per-file position, header, row state and phase; the palette stays.
            pos_q        <= '0;
            for (int i = 0; i < HDR_WORDS; i++) begin
              hdr_q[i] <= '0;
            end
            row_step_q   <= '0;
            row_idx_q    <= '0;
            col_q        <= '0;
            row_width_q  <= '0;
            row_start_q  <= '0;
            phase_q      <= PH_HEADER;
            state_q      <= ST_IN;
          end
        end
        default: begin
          state_q <= ST_IN;
        end
      endcase
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.kind    = out_kind_q;
  assign out_o.pixel_x = out_x_q;
  assign out_o.pixel_y = out_y_q;
  assign out_o.red     = out_r_q;
  assign out_o.green   = out_g_q;
  assign out_o.blue    = out_b_q;
  assign out_o.status  = out_status_q;

`ifndef SYNTHESIS
  a_status_clears_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAT && last_q && out_free)
    |=> (pos_q == '0 && phase_q == PH_HEADER && out_kind_q == KIND_STATUS))
    else $error("file state not cleared after status transfer");

  a_row_fits_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> (row_width_q <= tile_w && row_width_q != '0))
    else $error("diamond row width out of range");

  a_column_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> (col_q < row_width_q))
    else $error("column index past end of row");

  a_status_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_STATUS)
    |-> (out_x_q == '0 && out_y_q == '0 && out_r_q == '0 && out_g_q == '0 && out_b_q == '0))
    else $error("status result carries pixel data");
`endif

endmodule
